// ----- design/spimc_pkg.sv -----
`default_nettype none
package spimc_pkg;

  localparam int FIFO_DEPTH    = 8;
  localparam int MAX_WORD_BITS = 32;
  localparam int MIN_WORD_BITS = 8;
  localparam int DATA_W        = 32;
  localparam int PTR_W         = $clog2(FIFO_DEPTH);
  localparam int CNT_W         = $clog2(FIFO_DEPTH + 1);
  localparam int KIND_W        = 3;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_W         = 9;
  localparam int WB_W          = 6;
  localparam int DIV_W         = 9;
  localparam int SEL_W         = 3;

  typedef logic [DATA_W-1:0] word_t;
  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [WB_W-1:0]   wbits_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK   = 3'd0,
    KIND_PUSH   = 3'd1,
    KIND_POP    = 3'd2,
    KIND_STATUS = 3'd3,
    KIND_SELECT = 3'd4,
    KIND_FLUSH  = 3'd5
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE      = 3'd0,
    CFG_WORD_BITS   = 3'd1,
    CFG_LSB_FIRST   = 3'd2,
    CFG_IDLE_HIGH   = 3'd3,
    CFG_TX_FALLING  = 3'd4,
    CFG_DIVIDER     = 3'd5
  } cfg_idx_t;

  function automatic wbits_t eff_bits(input wbits_t wb);
    wbits_t w;
    w = wb;
    if (w < WB_W'(MIN_WORD_BITS)) w = WB_W'(MIN_WORD_BITS);
    if (w > WB_W'(MAX_WORD_BITS)) w = WB_W'(MAX_WORD_BITS);
    return w;
  endfunction

  function automatic word_t word_mask(input wbits_t w);
    word_t m;
    m = '1;
    return m >> (7'(DATA_W) - {1'b0, w});
  endfunction

  function automatic logic out_bit(input word_t sw, input wbits_t w, input logic lsb);
    return lsb ? sw[0] : sw[5'(w - 6'd1)];
  endfunction

  function automatic word_t sample_in(input word_t sw, input wbits_t w, input logic lsb,
                                      input logic miso);
    word_t m;
    m = word_mask(w);
    if (lsb) return ((sw & m) >> 1) | (word_t'(miso) << (w - 6'd1));
    return ((sw << 1) | word_t'(miso)) & m;
  endfunction

  function automatic ptr_t ptr_inc(input ptr_t p);
    return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic ptr_t ptr_add(input ptr_t head, input cnt_t cnt);
    logic [PTR_W:0] s;
    s = (PTR_W + 1)'(head) + (PTR_W + 1)'(cnt);
    if (s >= (PTR_W + 1)'(FIFO_DEPTH)) s = s - (PTR_W + 1)'(FIFO_DEPTH);
    return s[PTR_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ----- design/spimc_ram.sv -----
`default_nettype none
module spimc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- design/spi_master_controller_core.sv -----
// Results: each result is registered and appears in the cycle after its item is accepted.
// Throughput: one item per cycle; the output register lets a new item in while a
//   result waits, so only a stalled output holds the input.
// Storage: transmit and receive FIFOs in two simple dual-port RAMs with a registered read.
// Reset (synchronous, rst_n low): configuration returns to its defaults; FIFO counts,
//   pointers, shifter and select bits clear at once; RAM contents stay undefined, no clearing pass.
`default_nettype none
module spi_master_controller_core (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [spimc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [spimc_pkg::CFG_W-1:0]         cfg_wdata,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [spimc_pkg::KIND_W-1:0]        in_kind,
  input  wire logic [spimc_pkg::DATA_W-1:0]        in_write_data,
  input  wire logic                                in_miso_in,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic      [spimc_pkg::DATA_W-1:0]        out_read_data,
  output logic                                     out_tx_full,
  output logic                                     out_tx_empty,
  output logic                                     out_rx_empty,
  output logic                                     out_busy_res,
  output logic                                     out_enabled_status,
  output logic                                     out_sclk_out,
  output logic                                     out_mosi_out,
  output logic                                     out_select0_pin,
  output logic                                     out_select1_pin
);

  logic                          enable_r;
  spimc_pkg::wbits_t             word_bits_r;
  logic                          lsb_first_r;
  logic                          idle_high_r;
  logic                          tx_falling_r;
  logic [spimc_pkg::DIV_W-1:0]   divider_r;

  spimc_pkg::cnt_t               tx_cnt_r, tx_cnt_nxt;
  spimc_pkg::ptr_t               tx_head_r, tx_head_nxt;
  spimc_pkg::cnt_t               rx_cnt_r, rx_cnt_nxt;
  spimc_pkg::ptr_t               rx_head_r, rx_head_nxt;
  spimc_pkg::word_t              shift_r, shift_nxt;
  spimc_pkg::wbits_t             bits_left_r, bits_left_nxt;
  logic [spimc_pkg::DIV_W-1:0]   hpc_r, hpc_nxt;
  logic                          clk_lvl_r, clk_lvl_nxt;
  logic [spimc_pkg::SEL_W-1:0]   sel_r, sel_nxt;
  logic                          dlvl_r, dlvl_nxt;
  logic                          load_pend_r, load_nxt;
  logic                          pop_nxt;

  logic                          res_valid_r;
  logic                          res_load_r;
  logic                          res_pop_r;
  logic                          res_full_r;
  logic                          res_tx_empty_r;
  logic                          res_rx_empty_r;
  logic                          res_busy_r;
  logic                          res_sclk_r;
  logic                          res_mosi_r;
  logic                          res_sel0_r;
  logic                          res_sel1_r;

  logic                          accept;
  spimc_pkg::wbits_t             eff;
  spimc_pkg::word_t              mask;
  spimc_pkg::word_t              tx_rdata, rx_rdata, rx_wdata;
  spimc_pkg::word_t              shift_eff;
  logic                          dlvl_eff;
  logic                          tx_we, tx_re, rx_we, rx_re;
  spimc_pkg::ptr_t               tx_waddr, rx_waddr;
  logic [spimc_pkg::DIV_W:0]     half_sum;
  logic [spimc_pkg::DIV_W-1:0]   half;
  logic [spimc_pkg::DIV_W-1:0]   hpc_inc;
  logic                          leading, rising, tx_edge;
  spimc_pkg::wbits_t             bl_dec;

  assign in_ready  = !res_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign eff       = spimc_pkg::eff_bits(word_bits_r);
  assign mask      = spimc_pkg::word_mask(eff);
  assign shift_eff = load_pend_r ? (tx_rdata & mask) : shift_r;
  assign dlvl_eff  = load_pend_r ? spimc_pkg::out_bit(tx_rdata & mask, eff, lsb_first_r)
                                 : dlvl_r;
  assign half_sum  = {1'b0, divider_r} + 10'd1;
  assign half      = (half_sum[spimc_pkg::DIV_W:1] == '0) ? 9'd1
                                                          : half_sum[spimc_pkg::DIV_W:1];
  assign hpc_inc   = hpc_r + 9'd1;
  assign leading   = !clk_lvl_r;
  assign rising    = idle_high_r ? !leading : leading;
  assign tx_edge   = (!rising) == tx_falling_r;
  assign bl_dec    = bits_left_r - 6'd1;

  spimc_ram #(
    .WIDTH (spimc_pkg::DATA_W),
    .DEPTH (spimc_pkg::FIFO_DEPTH)
  ) u_tx_ram (
    .clk   (clk),
    .we    (tx_we),
    .waddr (tx_waddr),
    .wdata (in_write_data),
    .re    (tx_re),
    .raddr (tx_head_r),
    .rdata (tx_rdata)
  );

  spimc_ram #(
    .WIDTH (spimc_pkg::DATA_W),
    .DEPTH (spimc_pkg::FIFO_DEPTH)
  ) u_rx_ram (
    .clk   (clk),
    .we    (rx_we),
    .waddr (rx_waddr),
    .wdata (rx_wdata),
    .re    (rx_re),
    .raddr (rx_head_r),
    .rdata (rx_rdata)
  );

  always_comb begin
    tx_cnt_nxt    = tx_cnt_r;
    tx_head_nxt   = tx_head_r;
    rx_cnt_nxt    = rx_cnt_r;
    rx_head_nxt   = rx_head_r;
    shift_nxt     = shift_eff;
    bits_left_nxt = bits_left_r;
    hpc_nxt       = hpc_r;
    clk_lvl_nxt   = clk_lvl_r;
    sel_nxt       = sel_r;
    dlvl_nxt      = dlvl_eff;
    load_nxt      = 1'b0;
    pop_nxt       = 1'b0;
    tx_we         = 1'b0;
    tx_re         = 1'b0;
    rx_we         = 1'b0;
    rx_re         = 1'b0;
    tx_waddr      = spimc_pkg::ptr_add(tx_head_r, tx_cnt_r);
    rx_waddr      = spimc_pkg::ptr_add(rx_head_r, rx_cnt_r);
    rx_wdata      = '0;
    if (accept) begin
      unique case (in_kind)
        spimc_pkg::KIND_TICK: begin
          if (enable_r) begin
            if (bits_left_r == '0) begin
              if (tx_cnt_r != '0) begin
                tx_re         = 1'b1;
                tx_head_nxt   = spimc_pkg::ptr_inc(tx_head_r);
                tx_cnt_nxt    = tx_cnt_r - 1'b1;
                bits_left_nxt = eff;
                hpc_nxt       = '0;
                clk_lvl_nxt   = 1'b0;
                load_nxt      = 1'b1;
              end
            end else if (hpc_inc < half) begin
              hpc_nxt = hpc_inc;
            end else begin
              hpc_nxt     = '0;
              clk_lvl_nxt = ~clk_lvl_r;
              if (tx_edge) begin
                if (leading || bits_left_r > 6'd1) begin
                  dlvl_nxt = spimc_pkg::out_bit(shift_eff, eff, lsb_first_r);
                end
              end else begin
                shift_nxt = spimc_pkg::sample_in(shift_eff, eff, lsb_first_r, in_miso_in);
              end
              if (!leading) begin
                bits_left_nxt = bl_dec;
                if (bl_dec == '0 && rx_cnt_r < spimc_pkg::CNT_W'(spimc_pkg::FIFO_DEPTH)) begin
                  rx_we      = 1'b1;
                  rx_wdata   = shift_nxt & mask;
                  rx_cnt_nxt = rx_cnt_r + 1'b1;
                end
              end
            end
          end
        end
        spimc_pkg::KIND_PUSH: begin
          if (tx_cnt_r < spimc_pkg::CNT_W'(spimc_pkg::FIFO_DEPTH)) begin
            tx_we      = 1'b1;
            tx_cnt_nxt = tx_cnt_r + 1'b1;
          end
        end
        spimc_pkg::KIND_POP: begin
          if (rx_cnt_r != '0) begin
            rx_re       = 1'b1;
            rx_head_nxt = spimc_pkg::ptr_inc(rx_head_r);
            rx_cnt_nxt  = rx_cnt_r - 1'b1;
            pop_nxt     = 1'b1;
          end
        end
        spimc_pkg::KIND_SELECT: begin
          sel_nxt = in_write_data[spimc_pkg::SEL_W-1:0];
        end
        spimc_pkg::KIND_FLUSH: begin
          tx_cnt_nxt  = '0;
          tx_head_nxt = '0;
          rx_cnt_nxt  = '0;
          rx_head_nxt = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r     <= 1'b0;
      word_bits_r  <= 6'd8;
      lsb_first_r  <= 1'b0;
      idle_high_r  <= 1'b0;
      tx_falling_r <= 1'b1;
      divider_r    <= 9'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        spimc_pkg::CFG_ENABLE:     enable_r     <= cfg_wdata[0];
        spimc_pkg::CFG_WORD_BITS:  word_bits_r  <= cfg_wdata[spimc_pkg::WB_W-1:0];
        spimc_pkg::CFG_LSB_FIRST:  lsb_first_r  <= cfg_wdata[0];
        spimc_pkg::CFG_IDLE_HIGH:  idle_high_r  <= cfg_wdata[0];
        spimc_pkg::CFG_TX_FALLING: tx_falling_r <= cfg_wdata[0];
        spimc_pkg::CFG_DIVIDER:    divider_r    <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_cnt_r    <= '0;
      tx_head_r   <= '0;
      rx_cnt_r    <= '0;
      rx_head_r   <= '0;
      shift_r     <= '0;
      bits_left_r <= '0;
      hpc_r       <= '0;
      clk_lvl_r   <= 1'b0;
      sel_r       <= '0;
      dlvl_r      <= 1'b0;
      load_pend_r <= 1'b0;
    end else begin
      tx_cnt_r    <= tx_cnt_nxt;
      tx_head_r   <= tx_head_nxt;
      rx_cnt_r    <= rx_cnt_nxt;
      rx_head_r   <= rx_head_nxt;
      shift_r     <= shift_nxt;
      bits_left_r <= bits_left_nxt;
      hpc_r       <= hpc_nxt;
      clk_lvl_r   <= clk_lvl_nxt;
      sel_r       <= sel_nxt;
      dlvl_r      <= dlvl_nxt;
      load_pend_r <= load_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (accept) begin
      res_valid_r <= 1'b1;
    end else if (out_ready) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_load_r     <= load_nxt;
      res_pop_r      <= pop_nxt;
      res_full_r     <= tx_cnt_nxt >= spimc_pkg::CNT_W'(spimc_pkg::FIFO_DEPTH);
      res_tx_empty_r <= tx_cnt_nxt == '0;
      res_rx_empty_r <= rx_cnt_nxt == '0;
      res_busy_r     <= (bits_left_nxt != '0) || (tx_cnt_nxt != '0);
      res_sclk_r     <= clk_lvl_nxt ^ idle_high_r;
      res_mosi_r     <= dlvl_nxt;
      res_sel0_r     <= sel_nxt[0] ^ sel_nxt[2] ^ 1'b1;
      res_sel1_r     <= sel_nxt[1] ^ sel_nxt[2] ^ 1'b1;
    end
  end

  assign out_valid          = res_valid_r;
  assign out_read_data      = res_pop_r ? (rx_rdata & mask) : '0;
  assign out_tx_full        = res_full_r;
  assign out_tx_empty       = res_tx_empty_r;
  assign out_rx_empty       = res_rx_empty_r;
  assign out_busy_res       = res_busy_r;
  assign out_enabled_status = enable_r;
  assign out_sclk_out       = res_sclk_r;
  assign out_mosi_out       = res_load_r ? spimc_pkg::out_bit(tx_rdata & mask, eff, lsb_first_r)
                                         : res_mosi_r;
  assign out_select0_pin    = res_sel0_r;
  assign out_select1_pin    = res_sel1_r;

endmodule
`default_nettype wire

// ----- design/spimc_chk.sv -----
`default_nettype none
module spimc_chk (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_valid,
  input wire logic                         in_ready,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [spimc_pkg::DATA_W-1:0] out_read_data,
  input wire logic                         out_tx_full,
  input wire logic                         out_tx_empty,
  input wire logic                         out_busy_res
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_data))
    else $error("result changed while stalled");

  a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_tx_full && out_tx_empty))
    else $error("transmit FIFO full and empty at once");

  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_busy_res |-> out_tx_empty)
    else $error("not busy with transmit words pending");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_item_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted item gave no result");

endmodule

bind spi_master_controller_core spimc_chk u_spimc_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_read_data (out_read_data),
  .out_tx_full   (out_tx_full),
  .out_tx_empty  (out_tx_empty),
  .out_busy_res  (out_busy_res)
);
`default_nettype wire

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
module tb;
  import spimc_pkg::*;

  localparam logic [KIND_W-1:0] KIND_SPARE6 = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE7 = 3'd7;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 90;

  typedef struct packed {
    word_t rd;
    logic  tx_full;
    logic  tx_empty;
    logic  rx_empty;
    logic  busy;
    logic  enabled;
    logic  sclk;
    logic  mosi;
    logic  sel0;
    logic  sel1;
  } spi_status_t;

  typedef struct packed {
    logic              is_cfg;
    logic [KIND_W-1:0] code;
    word_t             data;
    logic              miso;
    logic [7:0]        reps;
    logic              chk;
    spi_status_t       want;
  } spi_step_t;

  localparam spi_status_t QUIET =
    '{32'h0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1};
  localparam spi_status_t QUIET_SEL5 =
    '{32'h0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0};

  localparam spi_step_t DIRECTED [13] = '{
    '{1'b0, KIND_STATUS, 32'h0000_0000, 1'b0, 8'd1, 1'b1, QUIET},
    '{1'b0, KIND_POP,    32'hFFFF_FFFF, 1'b1, 8'd1, 1'b1, QUIET},
    '{1'b0, KIND_SELECT, 32'hFFFF_FFF8, 1'b0, 8'd1, 1'b1, QUIET},
    '{1'b0, KIND_SELECT, 32'h0000_0005, 1'b1, 8'd1, 1'b1, QUIET_SEL5},
    '{1'b0, KIND_SPARE6, 32'h5555_5555, 1'b0, 8'd1, 1'b0, '0},
    '{1'b0, KIND_SPARE7, 32'hAAAA_AAAA, 1'b1, 8'd1, 1'b0, '0},
    '{1'b0, KIND_PUSH,   32'hFFFF_FFFF, 1'b0, 8'd9, 1'b0, '0},
    '{1'b0, KIND_TICK,   32'h0000_0000, 1'b1, 8'd1, 1'b0, '0},
    '{1'b0, KIND_FLUSH,  32'h0000_0000, 1'b0, 8'd1, 1'b1, QUIET_SEL5},
    '{1'b0, KIND_PUSH,   32'h0000_00A5, 1'b0, 8'd1, 1'b0, '0},
    '{1'b1, CFG_ENABLE,  32'h0000_0001, 1'b0, 8'd1, 1'b0, '0},
    '{1'b0, KIND_TICK,   32'h0000_0000, 1'b1, 8'd6, 1'b0, '0},
    '{1'b0, KIND_POP,    32'h0000_0000, 1'b0, 8'd1, 1'b0, '0}
  };

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [KIND_W-1:0]    in_kind = '0;
  word_t                in_write_data = '0;
  logic                 in_miso_in = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  word_t                out_read_data;
  logic                 out_tx_full, out_tx_empty, out_rx_empty, out_busy_res;
  logic                 out_enabled_status, out_sclk_out, out_mosi_out;
  logic                 out_select0_pin, out_select1_pin;

  spi_master_controller_core dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_kind(in_kind),
    .in_write_data(in_write_data), .in_miso_in(in_miso_in),
    .out_valid(out_valid), .out_ready(out_ready), .out_read_data(out_read_data),
    .out_tx_full(out_tx_full), .out_tx_empty(out_tx_empty),
    .out_rx_empty(out_rx_empty), .out_busy_res(out_busy_res),
    .out_enabled_status(out_enabled_status), .out_sclk_out(out_sclk_out),
    .out_mosi_out(out_mosi_out), .out_select0_pin(out_select0_pin),
    .out_select1_pin(out_select1_pin)
  );

  // shadow of the controller
  logic        en_r, lsb_r, idle_hi_r, tx_fall_r;
  logic [5:0]  wb_r;
  logic [8:0]  div_r;
  word_t       tx_mem [FIFO_DEPTH];
  word_t       rx_mem [FIFO_DEPTH];
  int          tx_cnt, rx_cnt, tx_hd, rx_hd;
  word_t       shreg;
  int          bits_left, half_cnt;
  logic        clk_lvl, mosi_lvl;
  logic [2:0]  sel_r;

  spi_status_t status_due [$];
  int          errors = 0;
  int          cycles = 0;
  logic        tx_calm = 1'b0;
  logic        rx_calm = 1'b0;
  int          hold_req = 0;

  function automatic int word_span();
    int w;
    w = wb_r;
    if (w < MIN_WORD_BITS) w = MIN_WORD_BITS;
    if (w > MAX_WORD_BITS) w = MAX_WORD_BITS;
    return w;
  endfunction

  function automatic word_t span_mask();
    return word_t'((64'd1 << word_span()) - 64'd1);
  endfunction

  function automatic logic lead_bit();
    return lsb_r ? shreg[0] : shreg[word_span() - 1];
  endfunction

  function automatic void shift_in(logic m);
    if (lsb_r) shreg = ((shreg & span_mask()) >> 1) | (word_t'(m) << (word_span() - 1));
    else shreg = ((shreg << 1) | word_t'(m)) & span_mask();
  endfunction

  function automatic void spi_reset();
    en_r = 1'b0; wb_r = 6'd8; lsb_r = 1'b0; idle_hi_r = 1'b0;
    tx_fall_r = 1'b1; div_r = 9'd1;
    tx_cnt = 0; rx_cnt = 0; tx_hd = 0; rx_hd = 0;
    shreg = '0; bits_left = 0; half_cnt = 0; clk_lvl = 1'b0;
    mosi_lvl = 1'b0; sel_r = '0;
  endfunction

  function automatic void spi_set_reg(cfg_idx_t idx, logic [8:0] v);
    case (idx)
      CFG_ENABLE:     en_r = v[0];
      CFG_WORD_BITS:  wb_r = v[5:0];
      CFG_LSB_FIRST:  lsb_r = v[0];
      CFG_IDLE_HIGH:  idle_hi_r = v[0];
      CFG_TX_FALLING: tx_fall_r = v[0];
      CFG_DIVIDER:    div_r = v;
      default: ;
    endcase
  endfunction

  function automatic void sclk_tick(logic m);
    int   half;
    logic leading, rising, tx_edge;
    if (!en_r) return;
    if (bits_left == 0) begin
      if (tx_cnt != 0) begin
        shreg = tx_mem[tx_hd] & span_mask();
        tx_hd = (tx_hd + 1) % FIFO_DEPTH;
        tx_cnt--;
        bits_left = word_span();
        half_cnt = 0;
        clk_lvl = 1'b0;
        mosi_lvl = lead_bit();
      end
      return;
    end
    half = (int'(div_r) + 1) >> 1;
    if (half == 0) half = 1;
    half_cnt = (half_cnt + 1) & 'h1FF;
    if (half_cnt < half) return;
    half_cnt = 0;
    leading = (clk_lvl == 1'b0);
    clk_lvl = ~clk_lvl;
    rising = idle_hi_r ? !leading : leading;
    tx_edge = ((rising ? 1'b0 : 1'b1) == tx_fall_r);
    if (tx_edge) begin
      if (leading || bits_left > 1) mosi_lvl = lead_bit();
    end else begin
      shift_in(m);
    end
    if (!leading) begin
      bits_left--;
      if (bits_left == 0 && rx_cnt < FIFO_DEPTH) begin
        rx_mem[(rx_hd + rx_cnt) % FIFO_DEPTH] = shreg & span_mask();
        rx_cnt++;
      end
    end
  endfunction

  function automatic spi_status_t spi_apply_item(logic [KIND_W-1:0] k, word_t d, logic m);
    spi_status_t s;
    s = '0;
    case (k)
      KIND_TICK: sclk_tick(m);
      KIND_PUSH: begin
        if (tx_cnt < FIFO_DEPTH) begin
          tx_mem[(tx_hd + tx_cnt) % FIFO_DEPTH] = d;
          tx_cnt++;
        end
      end
      KIND_POP: begin
        if (rx_cnt != 0) begin
          s.rd = rx_mem[rx_hd] & span_mask();
          rx_hd = (rx_hd + 1) % FIFO_DEPTH;
          rx_cnt--;
        end
      end
      KIND_SELECT: sel_r = d[2:0];
      KIND_FLUSH: begin
        tx_cnt = 0; rx_cnt = 0; tx_hd = 0; rx_hd = 0;
      end
      default: ;
    endcase
    s.tx_full  = (tx_cnt >= FIFO_DEPTH);
    s.tx_empty = (tx_cnt == 0);
    s.rx_empty = (rx_cnt == 0);
    s.busy     = (bits_left != 0 || tx_cnt != 0);
    s.enabled  = en_r;
    s.sclk     = clk_lvl ^ idle_hi_r;
    s.mosi     = mosi_lvl;
    s.sel0     = sel_r[0] ^ sel_r[2] ^ 1'b1;
    s.sel1     = sel_r[1] ^ sel_r[2] ^ 1'b1;
    return s;
  endfunction

  task automatic send(logic [KIND_W-1:0] k, word_t d, logic m, logic chk, spi_status_t want);
    spi_status_t s;
    if (!tx_calm && $urandom_range(99) < 36) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 36);
    end
    in_valid <= 1'b1;
    in_kind <= k;
    in_write_data <= d;
    in_miso_in <= m;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    s = spi_apply_item(k, d, m);
    status_due.push_back(chk ? want : s);
  endtask

  task automatic park();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (status_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(cfg_idx_t idx, logic [8:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    spi_set_reg(idx, v);
  endtask

  task automatic cfg_done();
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic note_diff(string f, word_t e, word_t a);
    if (e !== a) begin
      errors++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, f, e, a);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  int rx_hold = 0;
  int hold_seen = 0;
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      rx_hold = HOLD_CYCLES;
    end
    if (rx_hold > 0) begin
      rx_hold--;
      out_ready <= 1'b0;
    end else if (rx_calm) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= 36);
    end
  end

  always @(negedge clk) begin
    spi_status_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_read_data, out_tx_full, out_tx_empty, out_rx_empty, out_busy_res,
              out_enabled_status, out_sclk_out, out_mosi_out, out_select0_pin,
              out_select1_pin};
      if (status_due.size() == 0) begin
        errors++;
        $display("%0t: item with none expected, actual %h", $time, got);
      end else begin
        want = status_due.pop_front();
        note_diff("read_data", want.rd, got.rd);
        note_diff("tx_full", want.tx_full, got.tx_full);
        note_diff("tx_empty", want.tx_empty, got.tx_empty);
        note_diff("rx_empty", want.rx_empty, got.rx_empty);
        note_diff("busy_res", want.busy, got.busy);
        note_diff("enabled_status", want.enabled, got.enabled);
        note_diff("sclk_out", want.sclk, got.sclk);
        note_diff("mosi_out", want.mosi, got.mosi);
        note_diff("select0_pin", want.sel0, got.sel0);
        note_diff("select1_pin", want.sel1, got.sel1);
      end
    end
  end

  initial begin
    spi_step_t         row;
    int                p, i, n, r, push_w, pop_w;
    logic [5:0]        wb;
    logic [8:0]        dv;
    logic              en_bit;
    logic [KIND_W-1:0] k;
    word_t             junk;

    spi_reset();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < $size(DIRECTED); i++) begin
      row = DIRECTED[i];
      if (row.is_cfg) begin
        park();
        drain();
        cfg_write(cfg_idx_t'(row.code), row.data[8:0]);
        cfg_done();
      end else begin
        repeat (row.reps) send(row.code, row.data, row.miso, row.chk, row.want);
      end
    end

    for (p = 0; p < 12; p++) begin
      park();
      drain();
      case (p)
        0: wb = 6'd8;
        1: wb = 6'd0;
        2: wb = 6'd63;
        3: wb = 6'd32;
        4: wb = 6'd7;
        6: wb = 6'd33;
        default: wb = ($urandom_range(7) == 0) ? 6'($urandom_range(63))
                                               : 6'($urandom_range(8, 16));
      endcase
      case (p)
        2: dv = 9'd511;
        3: dv = 9'd0;
        5: dv = 9'd2;
        6: dv = 9'($urandom_range(40));
        default: dv = 9'($urandom_range(3) * 2 + 1);
      endcase
      en_bit = (p == 7) ? 1'b0 : ($urandom_range(9) != 0);
      junk = $urandom();
      cfg_write(CFG_ENABLE, {junk[7:0], en_bit});
      cfg_write(CFG_WORD_BITS, {junk[10:8], wb});
      cfg_write(CFG_LSB_FIRST, {junk[18:11], 1'($urandom_range(1))});
      cfg_write(CFG_IDLE_HIGH, {junk[26:19], 1'($urandom_range(1))});
      cfg_write(CFG_TX_FALLING, {junk[31:27], 4'($urandom_range(15))});
      cfg_write(CFG_DIVIDER, dv);
      cfg_done();

      tx_calm = (p == 8);
      rx_calm = (p == 8);
      push_w = (p == 4) ? 40 : $urandom_range(5, 20);
      pop_w = (p == 4) ? 2 : $urandom_range(3, 15);
      if (p == 4) hold_req++;
      n = (p == 2) ? 300 : 100;

      for (i = 0; i < n; i++) begin
        if (p == 5 && i == n / 2) begin
          park();
          drain();
        end
        r = $urandom_range(99);
        if (i < 2 || r < push_w) k = KIND_PUSH;
        else if (r < push_w + pop_w) k = KIND_POP;
        else if (r < push_w + pop_w + 3) k = KIND_STATUS;
        else if (r < push_w + pop_w + 6) k = KIND_SELECT;
        else if (r < push_w + pop_w + 8) k = KIND_FLUSH;
        else if (r < push_w + pop_w + 10) k = $urandom_range(1) ? KIND_SPARE6 : KIND_SPARE7;
        else k = KIND_TICK;
        send(k, $urandom(), 1'($urandom_range(1)), 1'b0, '0);
      end
    end

    tx_calm = 1'b0;
    rx_calm = 1'b0;
    park();
    drain();
    repeat (8) @(posedge clk);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

// ----- files.f -----
design/spimc_pkg.sv
design/spimc_ram.sv
design/spi_master_controller_core.sv
design/spimc_chk.sv
dv/tb.sv
